FILE: rtl/core/sledpg_pkg.sv
`timescale 1ns / 1ps
// Shared types, field layouts and constants of the status LED pattern generator.
// Depends on nothing; every other file of the block imports it.
package sledpg_pkg;

  // Status codes shown on the result stream.
  typedef enum logic [2:0] {
    STATUS_AMBER  = 3'd0,
    STATUS_GREEN  = 3'd1,
    STATUS_RED    = 3'd2,
    STATUS_CYAN   = 3'd3,
    STATUS_YELLOW = 3'd4,
    STATUS_BLUE   = 3'd5
  } status_e;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_DAILY_MODE     = 3'd0,
    CFG_SOC_LIMIT      = 3'd1,
    CFG_BMS_READY_CODE = 3'd2,
    CFG_STROBE_ON_MS   = 3'd3,
    CFG_STROBE_OFF_MS  = 3'd4
  } cfg_reg_e;

  localparam int unsigned CfgIndexWidth = 3;
  localparam int unsigned CfgDataWidth  = 16;

  // Input item, first field in the highest bits.
  typedef struct packed {
    logic       stop_request;
    logic [9:0] charge_level;
    logic       test_running;
    logic       test_failed;
    logic [7:0] bms_code;
    logic       bms_valid;
    logic       charging;
    logic       unlocking;
    logic       locked;
    logic [31:0] now_ms;
  } in_item_t;

  // Result item, first field in the highest bits.
  typedef struct packed {
    status_e    status_id;
    logic [7:0] level;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } out_item_t;

  localparam int unsigned InBits   = $bits(in_item_t);
  localparam int unsigned OutBits  = $bits(out_item_t);
  localparam int unsigned InTdataW  = ((InBits + 7) / 8) * 8;
  localparam int unsigned OutTdataW = ((OutBits + 7) / 8) * 8;

  // Decision carried from the priority stage to the output stage.
  typedef struct packed {
    logic       red;
    logic       green;
    logic       blue;
    logic       breathe;
    logic       fast;
    logic [7:0] level;
    status_e    status_id;
  } decision_t;

  // Levels and register reset values.
  localparam logic [7:0]  ChannelOn     = 8'd255;
  localparam logic [7:0]  LevelFull     = 8'd255;
  localparam logic [7:0]  LevelTest     = 8'd128;
  localparam logic [7:0]  LevelSolid    = 8'd60;
  localparam logic [7:0]  LevelStandby  = 8'd40;
  localparam logic [9:0]  SocLimitReset = 10'd800;
  localparam logic [7:0]  BmsReadyReset = 8'd1;
  localparam logic [15:0] StrobeOnReset  = 16'd50;
  localparam logic [15:0] StrobeOffReset = 16'd800;

  // Breathing: phase increments per ms for periods of 2*pi*125 and 2*pi*500 ms.
  localparam logic [22:0] RateFast = 23'd5468522;
  localparam logic [22:0] RateSlow = 23'd1367131;
  localparam logic [7:0]  FastBase = 8'd50;
  localparam logic [7:0]  FastSpan = 8'd205;
  localparam logic [7:0]  SlowBase = 8'd30;
  localparam logic [7:0]  SlowSpan = 8'd225;

  // Sine table generation, Q30 Taylor series, evaluated at elaboration only.
  localparam logic [63:0] HalfPiQ30 = 64'd1686629713;
  localparam logic [8:0]  TaylorDiv [8] = '{9'd6, 9'd20, 9'd42, 9'd72,
                                             9'd110, 9'd156, 9'd210, 9'd272};

  // round(16384 * sin(k * (pi/2) / 2^qbits)) for 0 <= k <= 2^qbits.
  function automatic logic [14:0] quarter_sine(input int unsigned k,
                                               input int unsigned qbits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint      sum;
    logic [63:0] rounded;
    x = (64'(k) * HalfPiQ30) >> qbits;
    x2 = (x * x) >> 30;
    term = x;
    sum = longint'(x);
    for (int n = 0; n < 8; n++) begin
      term = ((term * x2) >> 30) / 64'(TaylorDiv[n]);
      if ((n % 2) == 0) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    rounded = (64'(sum) + 64'd32768) >> 16;
    return rounded[14:0];
  endfunction

endpackage

FILE: rtl/core/sledpg_breathe.sv
`timescale 1ns / 1ps
// Breathing brightness: quarter-wave sine lookup and base plus scaled span.
// Depends on sledpg_pkg for the table generator and the base and span constants.
module sledpg_breathe import sledpg_pkg::*; #(
  parameter int unsigned SINE_INDEX_BITS = 10
) (
  input  logic [SINE_INDEX_BITS-1:0] idx_i,
  input  logic                       fast_i,
  output logic [7:0]                 level_o
);

  localparam int unsigned QB      = SINE_INDEX_BITS - 2;
  localparam int unsigned Quarter = 1 << QB;

  typedef logic [14:0] qtab_t [Quarter];

  function automatic qtab_t build_qtab();
    qtab_t tab;
    for (int k = 0; k < Quarter; k++) begin
      tab[k] = quarter_sine(k, QB);
    end
    return tab;
  endfunction

  localparam qtab_t       QTab = build_qtab();
  localparam logic [14:0] Peak = quarter_sine(Quarter, QB);

  logic [1:0]    quad;
  logic [QB-1:0] j;
  logic [QB:0]   k;
  logic [14:0]   s;
  logic [15:0]   entry;
  logic [23:0]   prod;
  logic [7:0]    base;
  logic [7:0]    span;
  logic [8:0]    sum;

  always_comb begin
    quad = idx_i[SINE_INDEX_BITS-1 -: 2];
    j    = idx_i[QB-1:0];
    // Odd quadrants run the quarter wave backwards.
    k    = quad[0] ? ((QB+1)'(Quarter) - {1'b0, j}) : {1'b0, j};
    s    = k[QB] ? Peak : QTab[k[QB-1:0]];
    entry = quad[1] ? (16'd16384 - 16'(s)) : (16'd16384 + 16'(s));
    base = fast_i ? FastBase : SlowBase;
    span = fast_i ? FastSpan : SlowSpan;
    prod = 24'(entry) * 24'(span);
    sum  = 9'(base) + 9'(prod[23:15]);
    level_o = sum[7:0];
  end

endmodule

FILE: rtl/core/status_led_pattern_generator.sv
// Status LED pattern generator.
// Each request on the slave stream is one status update: a millisecond timestamp
// and the vehicle status flags. For every accepted request the block sends exactly
// one result on the master stream with the red, green and blue channel values, an
// overall brightness and a status code, chosen by fixed priority: self-test failure
// (red strobe), test running (yellow), manual stop (fast cyan breathe), unsafe plug
// (red), charging (blue at the daily ceiling, else slow green breathe), locked
// (green when the battery manager is ready, else amber), otherwise all zero.
// The configuration channel writes at most one register per request and is always ready;
// write it only while no update is in flight.
// Pipeline: three register stages (input, priority decision, result); a request
// accepted into the input register moves on through the decision and result registers.
// Throughput: one request per cycle while the receiver does not stall; the only loop is
// the strobe timer, read and updated in the same cycle in the decision stage.
// Each stage holds when the stage after it is full and stalled, so the slave side
// keeps taking requests until all three stages are full behind a stalled receiver.
// Reset empties the pipeline, loads the register defaults and lights the strobe
// with its time mark at zero.
`timescale 1ns / 1ps
// Depends on sledpg_pkg and sledpg_breathe.
module status_led_pattern_generator import sledpg_pkg::*; #(
  parameter int unsigned SINE_INDEX_BITS = 10,
  parameter int unsigned TIME_BITS       = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // Configuration write channel.
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CfgIndexWidth-1:0] cfg_index_i,
  input  logic [CfgDataWidth-1:0]  cfg_data_i,
  // Status updates.
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  // From bit 0: now_ms[31:0], locked, unlocking, charging, bms_valid, bms_code[7:0],
  // test_failed, test_running, charge_level[9:0], stop_request, zero fill.
  input  logic [InTdataW-1:0]      s_axis_tdata,
  // LED results.
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  // From bit 0: red[7:0], green[7:0], blue[7:0], level[7:0], status_id[2:0], zero fill.
  output logic [OutTdataW-1:0]     m_axis_tdata
);

  // Configuration registers.
  logic        daily_mode_q;
  logic [9:0]  soc_limit_q;
  logic [7:0]  bms_ready_code_q;
  logic [15:0] strobe_on_q;
  logic [15:0] strobe_off_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      daily_mode_q     <= 1'b0;
      soc_limit_q      <= SocLimitReset;
      bms_ready_code_q <= BmsReadyReset;
      strobe_on_q      <= StrobeOnReset;
      strobe_off_q     <= StrobeOffReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_DAILY_MODE:     daily_mode_q     <= cfg_data_i[0];
        CFG_SOC_LIMIT:      soc_limit_q      <= cfg_data_i[9:0];
        CFG_BMS_READY_CODE: bms_ready_code_q <= cfg_data_i[7:0];
        CFG_STROBE_ON_MS:   strobe_on_q      <= cfg_data_i;
        CFG_STROBE_OFF_MS:  strobe_off_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Pipeline control: each stage loads when it is empty or its content moves on.
  logic in_valid_q, dec_valid_q, out_valid_q;
  logic out_ready, dec_ready, in_ready;

  assign out_ready     = !out_valid_q || m_axis_tready;
  assign dec_ready     = !dec_valid_q || out_ready;
  assign in_ready      = !in_valid_q || dec_ready;
  assign s_axis_tready = in_ready;
  assign m_axis_tvalid = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      dec_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (dec_ready) begin
        dec_valid_q <= in_valid_q;
      end
      if (out_ready) begin
        out_valid_q <= dec_valid_q;
      end
    end
  end

  // Input register.
  in_item_t in_q;

  always_ff @(posedge clk_i) begin
    if (in_ready && s_axis_tvalid) begin
      in_q <= in_item_t'(s_axis_tdata[InBits-1:0]);
    end
  end

  // Decision stage: priority selection, strobe timer and breathing phase.
  logic                 strobe_lit_q, strobe_lit_d;
  logic [TIME_BITS-1:0] strobe_mark_q, strobe_mark_d;
  logic [TIME_BITS-1:0] now_t;
  logic [TIME_BITS-1:0] elapsed;
  logic [15:0]          strobe_limit;
  logic                 strobe_flip;
  logic                 unsafe_plug;
  logic                 at_ceiling;
  logic                 bms_ready;
  logic [22:0]          rate;
  logic [54:0]          phase_full;
  decision_t            dec_d, dec_q;
  logic [SINE_INDEX_BITS-1:0] idx_d, idx_q;

  always_comb begin
    now_t        = TIME_BITS'(in_q.now_ms);
    elapsed      = now_t - strobe_mark_q;
    strobe_limit = strobe_lit_q ? strobe_on_q : strobe_off_q;
    strobe_flip  = (elapsed >= TIME_BITS'(strobe_limit));
    strobe_lit_d  = strobe_lit_q;
    strobe_mark_d = strobe_mark_q;
    // The timer only runs while the self-test failure is the branch taken.
    if (in_valid_q && dec_ready && in_q.test_failed && strobe_flip) begin
      strobe_lit_d  = !strobe_lit_q;
      strobe_mark_d = now_t;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_lit_q  <= 1'b1;
      strobe_mark_q <= '0;
    end else begin
      strobe_lit_q  <= strobe_lit_d;
      strobe_mark_q <= strobe_mark_d;
    end
  end

  always_comb begin
    unsafe_plug = in_q.unlocking || (!in_q.locked && in_q.charging);
    at_ceiling  = daily_mode_q && (in_q.charge_level >= soc_limit_q);
    bms_ready   = in_q.bms_valid && (in_q.bms_code == bms_ready_code_q);

    dec_d = '{red: 1'b0, green: 1'b0, blue: 1'b0, breathe: 1'b0, fast: 1'b0,
              level: 8'd0, status_id: STATUS_AMBER};
    if (in_q.test_failed) begin
      dec_d.red       = strobe_lit_d;
      dec_d.level     = strobe_lit_d ? LevelFull : 8'd0;
      dec_d.status_id = STATUS_RED;
    end else if (in_q.test_running) begin
      dec_d.red       = 1'b1;
      dec_d.green     = 1'b1;
      dec_d.level     = LevelTest;
      dec_d.status_id = STATUS_YELLOW;
    end else if (in_q.stop_request) begin
      dec_d.green     = 1'b1;
      dec_d.blue      = 1'b1;
      dec_d.breathe   = 1'b1;
      dec_d.fast      = 1'b1;
      dec_d.status_id = STATUS_CYAN;
    end else if (unsafe_plug) begin
      dec_d.red       = 1'b1;
      dec_d.level     = LevelFull;
      dec_d.status_id = STATUS_RED;
    end else if (in_q.charging) begin
      if (at_ceiling) begin
        dec_d.blue      = 1'b1;
        dec_d.level     = LevelSolid;
        dec_d.status_id = STATUS_BLUE;
      end else begin
        dec_d.green     = 1'b1;
        dec_d.breathe   = 1'b1;
        dec_d.status_id = STATUS_GREEN;
      end
    end else if (in_q.locked) begin
      if (bms_ready) begin
        dec_d.green     = 1'b1;
        dec_d.level     = LevelSolid;
        dec_d.status_id = STATUS_GREEN;
      end else begin
        dec_d.red       = 1'b1;
        dec_d.green     = 1'b1;
        dec_d.level     = LevelStandby;
        dec_d.status_id = STATUS_AMBER;
      end
    end

    // Phase wraps modulo 2^32; its top bits index the sine table.
    rate       = in_q.stop_request ? RateFast : RateSlow;
    phase_full = 55'(in_q.now_ms) * 55'(rate);
    idx_d      = phase_full[31 -: SINE_INDEX_BITS];
  end

  always_ff @(posedge clk_i) begin
    if (dec_ready && in_valid_q) begin
      dec_q <= dec_d;
      idx_q <= idx_d;
    end
  end

  // Result stage.
  logic [7:0] breathe_level;
  out_item_t  out_d, out_q;

  sledpg_breathe #(
    .SINE_INDEX_BITS(SINE_INDEX_BITS)
  ) u_breathe (
    .idx_i  (idx_q),
    .fast_i (dec_q.fast),
    .level_o(breathe_level)
  );

  always_comb begin
    out_d.red       = dec_q.red   ? ChannelOn : 8'd0;
    out_d.green     = dec_q.green ? ChannelOn : 8'd0;
    out_d.blue      = dec_q.blue  ? ChannelOn : 8'd0;
    out_d.level     = dec_q.breathe ? breathe_level : dec_q.level;
    out_d.status_id = dec_q.status_id;
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && dec_valid_q) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tdata = OutTdataW'(out_q);

endmodule

FILE: rtl/core/sledpg_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the status LED pattern generator, bound to the top level.
// Depends on sledpg_pkg for the result layout and status codes.
module sledpg_checker import sledpg_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [OutTdataW-1:0] m_axis_tdata
);

  out_item_t res;
  assign res = out_item_t'(m_axis_tdata[OutBits-1:0]);

  // Reset empties the pipeline by the edge after it is seen.
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid)
    else $error("result valid during reset");

  // A stalled result stays and holds its data.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // Test running is solid yellow at the test level.
  a_yellow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res.status_id == STATUS_YELLOW |->
      res.red == ChannelOn && res.green == ChannelOn && res.blue == 8'd0 &&
      res.level == LevelTest)
    else $error("yellow result malformed");

  // The ceiling indication is solid blue.
  a_blue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res.status_id == STATUS_BLUE |->
      res.blue == ChannelOn && res.red == 8'd0 && res.green == 8'd0 &&
      res.level == LevelSolid)
    else $error("blue result malformed");

  // The fast breathe never drops below its base.
  a_cyan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res.status_id == STATUS_CYAN |->
      res.green == ChannelOn && res.blue == ChannelOn && res.red == 8'd0 &&
      res.level >= FastBase)
    else $error("cyan result malformed");

endmodule

bind status_led_pattern_generator sledpg_checker u_sledpg_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the status LED pattern generator.
// Depends on sledpg_pkg and status_led_pattern_generator; nothing else is read.
module tb_top;
  import sledpg_pkg::*;

  localparam int unsigned ClkHalf     = 4;
  localparam int unsigned ResetCycles = 5;
  localparam int unsigned DrainCycles = 4;        // pipeline is three stages deep
  localparam int unsigned RunLimit    = 400000;
  localparam int unsigned PhaseItems  = 175;
  localparam int unsigned FixedPhases = 6;
  localparam int unsigned NumPhases   = 8;
  localparam int unsigned MaxReports  = 10;

  // Index past the end of the register map; writes to it must be ignored.
  localparam logic [CfgIndexWidth-1:0] CfgSpareIdx = 3'd7;

  // Breathing arithmetic, kept separate from the design's own constants.
  localparam int unsigned WaveBits = 10;
  localparam int unsigned WaveLen  = 1 << WaveBits;
  localparam longint unsigned QuarterTurnQ30 = 64'd1686629713;
  localparam logic [31:0] CyanRate  = 32'd5468522;
  localparam logic [31:0] GreenRate = 32'd1367131;

  // Register settings walked by the random part: daily mode, charge ceiling,
  // ready code, strobe on time, strobe off time. Raw 16-bit words, so the
  // upper bits also check that each register keeps only its own width.
  localparam logic [15:0] PhaseRegs [FixedPhases][5] = '{
    '{16'd0,     16'd800,   16'd1,     16'd50,    16'd800},
    '{16'd1,     16'd0,     16'd0,     16'd1,     16'd1},
    '{16'd1,     16'd1000,  16'd255,   16'd65535, 16'd65535},
    '{16'hFFFF,  16'hFFFF,  16'hFF00,  16'd7,     16'd300},
    '{16'd0,     16'd500,   16'h005A,  16'd0,     16'd0},
    '{16'hFFFE,  16'h0155,  16'h00A5,  16'h5555,  16'hAAAA}
  };

  typedef enum logic {ROW_UPDATE, ROW_WRITE} row_kind_e;

  typedef struct {
    row_kind_e                kind;
    logic [CfgIndexWidth-1:0] reg_idx;
    logic [15:0]              reg_val;
    in_item_t                 upd;
    bit                       pinned;
    out_item_t                led;
  } plan_row_t;

  // A request may carry a hand-written expectation instead of the predicted one.
  typedef struct {
    bit        pinned;
    out_item_t led;
  } pin_t;

  logic                     clk_i         = 1'b0;
  logic                     rst_ni        = 1'b0;
  logic                     cfg_valid_i   = 1'b0;
  logic                     cfg_ready_o;
  logic [CfgIndexWidth-1:0] cfg_index_i   = '0;
  logic [CfgDataWidth-1:0]  cfg_data_i    = '0;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  logic [InTdataW-1:0]      s_axis_tdata  = '0;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  logic [OutTdataW-1:0]     m_axis_tdata;

  // Mirror of the block's registers and strobe timer, updated on handshakes.
  bit          daily_en       = 1'b0;
  logic [9:0]  soc_ceiling    = 10'd800;
  logic [7:0]  ready_code     = 8'd1;
  logic [15:0] lit_ms         = 16'd50;
  logic [15:0] dark_ms        = 16'd800;
  logic [31:0] strobe_mark_ms = '0;
  bit          lamp_lit       = 1'b1;

  logic [15:0] sine_q15 [WaveLen];

  plan_row_t   plan [$];
  pin_t        pin_q [$];
  out_item_t   led_q [$];

  // Settings of the current phase as the stimulus side sees them.
  logic [15:0] plan_on    = 16'd50;
  logic [15:0] plan_off   = 16'd800;
  logic [9:0]  plan_soc   = 10'd800;
  logic [7:0]  plan_ready = 8'd1;

  logic [31:0] ms_clock   = '0;
  int unsigned fault_left = 0;
  bit          steady     = 1'b0;

  int unsigned tick_cnt     = 0;
  int unsigned sent_cnt     = 0;
  int unsigned accepted_cnt = 0;
  int unsigned checked_cnt  = 0;
  int unsigned err_cnt      = 0;

  status_led_pattern_generator uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #ClkHalf clk_i = ~clk_i;

  always @(posedge clk_i) begin
    tick_cnt <= tick_cnt + 1;
  end

  // round(16384 * sin(k * (pi/2) / quarter)) by a Q30 Taylor series.
  function automatic int unsigned quarter_sin_q14(input int unsigned k);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          acc;
    x = (64'(k) * QuarterTurnQ30) / 64'(WaveLen / 4);
    x2 = (x * x) >> 30;
    term = x;
    acc = longint'(x);
    for (int n = 1; n <= 8; n++) begin
      term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
      if ((n % 2) == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    return 32'((64'(acc) + 64'd32768) >> 16);
  endfunction

  // Breathing brightness: base plus the table value scaled by the span.
  function automatic logic [7:0] glow_level(input logic [31:0] now, input logic [31:0] rate,
                                            input logic [7:0] base, input logic [7:0] span);
    logic [31:0] phase;
    logic [31:0] swing;
    phase = now * rate;
    swing = (32'(sine_q15[phase[31 -: WaveBits]]) * 32'(span)) >> 15;
    return base + swing[7:0];
  endfunction

  // Expected LED output for one status update; advances the strobe timer.
  function automatic out_item_t led_for_update(input in_item_t u);
    out_item_t   led;
    logic [31:0] held;
    logic [15:0] hold_limit;
    led = '0;
    if (u.test_failed) begin
      held = u.now_ms - strobe_mark_ms;
      hold_limit = lamp_lit ? lit_ms : dark_ms;
      if (held >= 32'(hold_limit)) begin
        lamp_lit = !lamp_lit;
        strobe_mark_ms = u.now_ms;
      end
      if (lamp_lit) begin
        led.red = 8'd255;
        led.level = 8'd255;
      end
      led.status_id = STATUS_RED;
    end else if (u.test_running) begin
      led.red = 8'd255;
      led.green = 8'd255;
      led.level = 8'd128;
      led.status_id = STATUS_YELLOW;
    end else if (u.stop_request) begin
      led.green = 8'd255;
      led.blue = 8'd255;
      led.level = glow_level(u.now_ms, CyanRate, 8'd50, 8'd205);
      led.status_id = STATUS_CYAN;
    end else if (u.unlocking || (!u.locked && u.charging)) begin
      led.red = 8'd255;
      led.level = 8'd255;
      led.status_id = STATUS_RED;
    end else if (u.charging) begin
      if (daily_en && u.charge_level >= soc_ceiling) begin
        led.blue = 8'd255;
        led.level = 8'd60;
        led.status_id = STATUS_BLUE;
      end else begin
        led.green = 8'd255;
        led.level = glow_level(u.now_ms, GreenRate, 8'd30, 8'd225);
        led.status_id = STATUS_GREEN;
      end
    end else if (u.locked) begin
      if (u.bms_valid && u.bms_code == ready_code) begin
        led.green = 8'd255;
        led.level = 8'd60;
        led.status_id = STATUS_GREEN;
      end else begin
        led.red = 8'd255;
        led.green = 8'd255;
        led.level = 8'd40;
        led.status_id = STATUS_AMBER;
      end
    end
    return led;
  endfunction

  function automatic in_item_t mk_upd(input logic [31:0] now, input logic locked,
                                      input logic unlocking, input logic charging,
                                      input logic bms_valid, input logic [7:0] code,
                                      input logic failed, input logic running,
                                      input logic [9:0] charge, input logic stop);
    in_item_t u;
    u.now_ms = now;
    u.locked = locked;
    u.unlocking = unlocking;
    u.charging = charging;
    u.bms_valid = bms_valid;
    u.bms_code = code;
    u.test_failed = failed;
    u.test_running = running;
    u.charge_level = charge;
    u.stop_request = stop;
    return u;
  endfunction

  function automatic out_item_t mk_led(input logic [7:0] r, input logic [7:0] g,
                                      input logic [7:0] b, input logic [7:0] lvl,
                                      input status_e id);
    out_item_t led;
    led.red = r;
    led.green = g;
    led.blue = b;
    led.level = lvl;
    led.status_id = id;
    return led;
  endfunction

  function automatic void add_update(input in_item_t u);
    plan_row_t row;
    row.kind = ROW_UPDATE;
    row.reg_idx = '0;
    row.reg_val = '0;
    row.upd = u;
    row.pinned = 1'b0;
    row.led = '0;
    plan.push_back(row);
  endfunction

  function automatic void add_pinned(input in_item_t u, input out_item_t led);
    plan_row_t row;
    row.kind = ROW_UPDATE;
    row.reg_idx = '0;
    row.reg_val = '0;
    row.upd = u;
    row.pinned = 1'b1;
    row.led = led;
    plan.push_back(row);
  endfunction

  function automatic void add_write(input logic [CfgIndexWidth-1:0] idx,
                                    input logic [15:0] val);
    plan_row_t row;
    row.kind = ROW_WRITE;
    row.reg_idx = idx;
    row.reg_val = val;
    row.upd = '0;
    row.pinned = 1'b0;
    row.led = '0;
    plan.push_back(row);
  endfunction

  // Random update shaped around the current settings. The timestamp mostly
  // creeps forward by up to twice the longer strobe time plus 4 ms, so the strobe
  // toggles often; self-test failures come mostly in runs, as in a real fault.
  function automatic in_item_t random_update();
    in_item_t    u;
    int unsigned pick;
    int unsigned reach;
    int          charge;
    u = '0;
    reach = 2 * ((plan_on > plan_off) ? int'(plan_on) : int'(plan_off)) + 4;
    pick = $urandom_range(0, 99);
    if (pick < 80) begin
      ms_clock = ms_clock + $urandom_range(0, reach);
    end else if (pick < 92) begin
      ms_clock = $urandom();
    end else begin
      ms_clock = 32'hFFFF_FFFF - $urandom_range(0, reach);
    end
    u.now_ms = ms_clock;
    if (fault_left != 0) begin
      u.test_failed = 1'b1;
      fault_left--;
    end else if ($urandom_range(0, 29) == 0) begin
      fault_left = $urandom_range(4, 30);
      u.test_failed = 1'b1;
    end else begin
      u.test_failed = ($urandom_range(0, 19) == 0);
    end
    u.test_running = ($urandom_range(0, 5) == 0);
    u.stop_request = ($urandom_range(0, 4) == 0);
    u.unlocking = ($urandom_range(0, 5) == 0);
    u.locked = ($urandom_range(0, 9) < 6);
    u.charging = $urandom_range(0, 1);
    u.bms_valid = ($urandom_range(0, 9) < 7);
    u.bms_code = $urandom_range(0, 1) ? plan_ready : 8'($urandom());
    if ($urandom_range(0, 9) < 4) begin
      // Hover around the charge ceiling to hit both sides of the compare.
      charge = int'(plan_soc) + int'($urandom_range(0, 4)) - 2;
      if (charge < 0) begin
        charge = 0;
      end else if (charge > 1023) begin
        charge = 1023;
      end
      u.charge_level = 10'(charge);
    end else begin
      u.charge_level = 10'($urandom_range(0, 1023));
    end
    return u;
  endfunction

  // Drop the update stream and wait until every expected result is back.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (led_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIndexWidth-1:0] idx, input logic [15:0] val);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Offer one status update, after a random gap except in steady stretches.
  task automatic send_update(input in_item_t u, input bit pinned, input out_item_t led);
    int unsigned         gap;
    pin_t                pin;
    logic [InTdataW-1:0] word;
    steady = (sent_cnt % 64) < 12;
    gap = steady ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pin.pinned = pinned;
    pin.led = led;
    pin_q.push_back(pin);
    word = '0;
    word[InBits-1:0] = u;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= word;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sent_cnt++;
  endtask

  // Result side: a random stall before each result, none in steady stretches.
  initial begin : result_sink
    int unsigned stall;
    @(posedge rst_ni);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 5);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
    end
  end

  // Handshakes are sampled right at the rising edge, before any of the
  // edge's nonblocking updates land, which is what the block itself sees.
  always @(posedge clk_i) begin : scoreboard
    pin_t      pin;
    out_item_t want;
    out_item_t got;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_DAILY_MODE:     daily_en = cfg_data_i[0];
          CFG_SOC_LIMIT:      soc_ceiling = cfg_data_i[9:0];
          CFG_BMS_READY_CODE: ready_code = cfg_data_i[7:0];
          CFG_STROBE_ON_MS:   lit_ms = cfg_data_i;
          CFG_STROBE_OFF_MS:  dark_ms = cfg_data_i;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        pin = pin_q.pop_front();
        want = led_for_update(in_item_t'(s_axis_tdata[InBits-1:0]));
        if (pin.pinned) begin
          want = pin.led;
        end
        led_q.push_back(want);
        accepted_cnt++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = out_item_t'(m_axis_tdata[OutBits-1:0]);
        if (led_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= MaxReports) begin
            $display("[%0t] LED result r=%0d g=%0d b=%0d lvl=%0d id=%0d with no update pending",
                     $time, got.red, got.green, got.blue, got.level, got.status_id);
          end
        end else begin
          want = led_q.pop_front();
          checked_cnt++;
          if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
              got.level !== want.level || got.status_id !== want.status_id) begin
            err_cnt++;
            if (err_cnt <= MaxReports) begin
              $display("[%0t] LED mismatch: want r=%0d g=%0d b=%0d lvl=%0d id=%0d",
                       $time, want.red, want.green, want.blue, want.level, want.status_id);
              $display("                   got  r=%0d g=%0d b=%0d lvl=%0d id=%0d",
                       got.red, got.green, got.blue, got.level, got.status_id);
            end
          end
        end
      end
    end
  end

  initial begin : watchdog
    wait (tick_cnt >= RunLimit);
    $display("Run stopped after %0d cycles with %0d results outstanding.",
             tick_cnt, led_q.size());
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    logic [15:0] regs [5];
    int unsigned quad;
    int unsigned slot;
    int unsigned mag;

    // Sine table, (sin + 1) / 2 in Q1.15, built from one quarter wave.
    for (int i = 0; i < WaveLen; i++) begin
      quad = i / (WaveLen / 4);
      slot = i % (WaveLen / 4);
      mag = quad[0] ? quarter_sin_q14(WaveLen / 4 - slot) : quarter_sin_q14(slot);
      sine_q15[i] = quad[1] ? 16'(16384 - mag) : 16'(16384 + mag);
    end

    // Directed part, under the reset settings first.
    // Standby and the two locked colors.
    add_pinned(mk_upd(32'd0, 0, 0, 0, 0, 8'd0, 0, 0, 10'd0, 0),
               mk_led(0, 0, 0, 0, STATUS_AMBER));
    add_pinned(mk_upd(32'd1, 1, 0, 0, 1, 8'd1, 0, 0, 10'd0, 0),
               mk_led(0, 255, 0, 60, STATUS_GREEN));
    add_pinned(mk_upd(32'd2, 1, 0, 0, 0, 8'd1, 0, 0, 10'd0, 0),
               mk_led(255, 255, 0, 40, STATUS_AMBER));
    // Unsafe plug: unlocking, or charging while not locked.
    add_pinned(mk_upd(32'd3, 0, 1, 0, 0, 8'd0, 0, 0, 10'd0, 0),
               mk_led(255, 0, 0, 255, STATUS_RED));
    add_pinned(mk_upd(32'd4, 0, 0, 1, 1, 8'd1, 0, 0, 10'd1000, 0),
               mk_led(255, 0, 0, 255, STATUS_RED));
    // Green breathe; daily mode is off, so a full battery stays green.
    add_update(mk_upd(32'd0, 1, 0, 1, 0, 8'd0, 0, 0, 10'd1000, 0));
    add_update(mk_upd(32'hFFFF_FFFF, 1, 0, 1, 1, 8'hFF, 0, 0, 10'h3FF, 0));
    // Cyan breathe wins over everything below it.
    add_update(mk_upd(32'd0, 0, 0, 0, 0, 8'd0, 0, 0, 10'd0, 1));
    add_update(mk_upd(32'h5555_5555, 1, 1, 1, 1, 8'h55, 0, 0, 10'h155, 1));
    add_update(mk_upd(32'hAAAA_AAAA, 0, 0, 0, 0, 8'hAA, 0, 0, 10'h2AA, 1));
    // A running self test wins over all but a failed one.
    add_pinned(mk_upd(32'd7, 0, 0, 0, 0, 8'd0, 0, 1, 10'd0, 0),
               mk_led(255, 255, 0, 128, STATUS_YELLOW));
    add_pinned(mk_upd(32'd8, 1, 1, 1, 1, 8'hFF, 0, 1, 10'h3FF, 1),
               mk_led(255, 255, 0, 128, STATUS_YELLOW));
    // Strobe starts lit with its mark at zero, goes dark at 50 ms, back on
    // 800 ms later, then across the 32-bit timestamp wrap.
    add_pinned(mk_upd(32'd10, 0, 0, 0, 0, 8'd0, 1, 0, 10'd0, 0),
               mk_led(255, 0, 0, 255, STATUS_RED));
    add_pinned(mk_upd(32'd50, 0, 0, 0, 0, 8'd0, 1, 0, 10'd0, 0),
               mk_led(0, 0, 0, 0, STATUS_RED));
    add_update(mk_upd(32'd849, 0, 0, 0, 0, 8'd0, 1, 0, 10'd0, 0));
    add_update(mk_upd(32'd850, 0, 0, 0, 0, 8'd0, 1, 0, 10'd0, 0));
    add_update(mk_upd(32'hFFFF_FFF0, 0, 0, 0, 0, 8'd0, 1, 0, 10'd0, 0));
    add_update(mk_upd(32'h0000_0010, 0, 0, 0, 0, 8'd0, 1, 0, 10'd0, 0));
    add_update(mk_upd(32'hFFFF_FFFF, 1, 1, 1, 1, 8'hFF, 1, 1, 10'h3FF, 1));
    // Extreme settings through oversized words: ceiling 1000, ready code 255,
    // zero strobe times, and a write to an index past the register map.
    add_write(CFG_DAILY_MODE, 16'hFFFF);
    add_write(CFG_SOC_LIMIT, 16'hFFE8);
    add_write(CFG_BMS_READY_CODE, 16'h00FF);
    add_write(CFG_STROBE_ON_MS, 16'd0);
    add_write(CFG_STROBE_OFF_MS, 16'd0);
    add_write(CfgSpareIdx, 16'hFFFF);
    add_pinned(mk_upd(32'd100, 1, 0, 1, 0, 8'd0, 0, 0, 10'd1000, 0),
               mk_led(0, 0, 255, 60, STATUS_BLUE));
    add_update(mk_upd(32'd12345, 1, 0, 1, 0, 8'd0, 0, 0, 10'd999, 0));
    add_pinned(mk_upd(32'd101, 1, 0, 1, 0, 8'd0, 0, 0, 10'h3FF, 0),
               mk_led(0, 0, 255, 60, STATUS_BLUE));
    add_pinned(mk_upd(32'd200, 1, 0, 0, 1, 8'hFF, 0, 0, 10'd0, 0),
               mk_led(0, 255, 0, 60, STATUS_GREEN));
    // With zero strobe times every failure update toggles, even at one time.
    add_update(mk_upd(32'd5, 0, 0, 0, 0, 8'd0, 1, 0, 10'd0, 0));
    add_update(mk_upd(32'd5, 0, 0, 0, 0, 8'd0, 1, 0, 10'd0, 0));

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        send_update(plan[i].upd, plan[i].pinned, plan[i].led);
      end
    end

    // Random part: fixed settings including the extremes, then random ones
    // with short strobe times.
    for (int p = 0; p < NumPhases; p++) begin
      if (p < FixedPhases) begin
        for (int r = 0; r < 5; r++) begin
          regs[r] = PhaseRegs[p][r];
        end
      end else begin
        regs[0] = 16'($urandom_range(0, 1));
        regs[1] = 16'($urandom_range(0, 1023));
        regs[2] = 16'($urandom_range(0, 255));
        regs[3] = 16'($urandom_range(1, 300));
        regs[4] = 16'($urandom_range(1, 300));
      end
      write_reg(CFG_DAILY_MODE, regs[0]);
      write_reg(CFG_SOC_LIMIT, regs[1]);
      write_reg(CFG_BMS_READY_CODE, regs[2]);
      write_reg(CFG_STROBE_ON_MS, regs[3]);
      write_reg(CFG_STROBE_OFF_MS, regs[4]);
      write_reg(CfgSpareIdx, 16'($urandom()));
      plan_soc = regs[1][9:0];
      plan_ready = regs[2][7:0];
      plan_on = regs[3];
      plan_off = regs[4];
      for (int k = 0; k < PhaseItems; k++) begin
        send_update(random_update(), 1'b0, '0);
      end
    end

    wait_idle();
    $display("Sent %0d status updates over %0d register settings; %0d LED results checked.",
             accepted_cnt, NumPhases + 2, checked_cnt);
    $display("Errors seen: %0d (unexpected results and field mismatches).", err_cnt);
    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/sledpg_pkg.sv
rtl/core/sledpg_breathe.sv
rtl/core/status_led_pattern_generator.sv
rtl/core/sledpg_checker.sv
test/tb_top.sv
